[rtl/core/assert_macros.svh]
// Assertion helpers included by the checker file txdra_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define TXDRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("txdra assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define TXDRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("txdra assertion failed");

`endif

[rtl/core/txdra_pkg.sv]
package txdra_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_CAP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_CAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_MASK = 3'd3;
  localparam int unsigned CFG_DATA_W = 32;

  // Input modes
  localparam logic MODE_REQUEST  = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [8:0]  DESC_CAP_RST  = 9'd256;
  localparam logic [15:0] BUF_CAP_RST   = 16'd1024;
  localparam logic [31:0] ADDR_MASK_RST = 32'h0000_ffff;
  localparam logic [7:0]  RING_MASK_RST = 8'hff;

  // Line accounting and thresholds
  localparam logic [6:0]  LINE_PAD    = 7'd126;
  localparam int unsigned LINE_SHIFT  = 6;
  localparam logic [15:0] MAX_LEN_OK  = 16'd1514;
  localparam logic [5:0]  STOP_LINES  = 6'd32;
  localparam logic [3:0]  WAKE_DESC   = 4'd8;
  localparam logic [7:0]  WAKE_LINES  = 8'd128;

  typedef struct packed {
    logic [8:0]  desc_cap;
    logic [15:0] buf_cap;
    logic [31:0] addr_mask;
    logic [7:0]  ring_mask;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] packet_length;
    logic [1:0]  egress_port;
    logic [63:0] dma_address;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  ring_index;
    logic [63:0] descriptor_low_word;
    logic [63:0] descriptor_high_word;
    logic        stop_queue;
    logic        wake_queue;
    logic        oversize;
  } result_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [10:0] lines;
  } slot_wr_t;

  function automatic logic [15:0] port_code(input logic [1:0] port);
    logic [15:0] code;
    unique case (port)
      2'd0: code = 16'h0102;
      2'd1: code = 16'h0408;
      2'd2: code = 16'h1020;
      2'd3: code = 16'h4080;
      default: code = 16'h0102;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/txdra_cfg.sv]
module txdra_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [txdra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [txdra_pkg::CFG_DATA_W-1:0]   cfg_data,
  output txdra_pkg::cfg_t                    cfg
);
  import txdra_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.desc_cap  <= DESC_CAP_RST;
      cfg_r.buf_cap   <= BUF_CAP_RST;
      cfg_r.addr_mask <= ADDR_MASK_RST;
      cfg_r.ring_mask <= RING_MASK_RST;
    end else if (cfg_we) begin
      // Writes to unused indexes are dropped
      case (cfg_index)
        CFG_DESC_CAP:  cfg_r.desc_cap  <= cfg_data[8:0];
        CFG_BUF_CAP:   cfg_r.buf_cap   <= cfg_data[15:0];
        CFG_ADDR_MASK: cfg_r.addr_mask <= cfg_data[31:0];
        CFG_RING_MASK: cfg_r.ring_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/txdra_slot_mem.sv]
module txdra_slot_mem #(
  parameter int RING_DEPTH = 256
) (
  input  logic                  clk,
  input  txdra_pkg::slot_wr_t   slot_wr,
  input  logic [7:0]            rd_index,
  output logic [10:0]           rd_lines
);
  import txdra_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [10:0]   mem [RING_DEPTH];
  logic [10:0]   rd_lines_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Reduce a ring index modulo the depth by conditional subtraction
  function automatic logic [AW-1:0] slot_addr(input logic [7:0] idx);
    logic [7:0] v;
    v = idx;
    for (int k = 7; k >= 0; k--) begin
      if ((RING_DEPTH << k) <= 255) begin
        if (v >= 8'(RING_DEPTH << k)) begin
          v = v - 8'(RING_DEPTH << k);
        end
      end
    end
    return AW'(v);
  endfunction

  assign wr_addr = slot_addr(slot_wr.index);
  assign rd_addr = slot_addr(rd_index);

  // Prefetch the slot the next completion frees; forward a same-cycle write
  always_ff @(posedge clk) begin
    if (slot_wr.en) begin
      mem[wr_addr] <= slot_wr.lines;
    end
    if (slot_wr.en && (wr_addr == rd_addr)) begin
      rd_lines_r <= slot_wr.lines;
    end else begin
      rd_lines_r <= mem[rd_addr];
    end
  end

  assign rd_lines = rd_lines_r;

endmodule

[rtl/core/txdra_engine.sv]
module txdra_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  txdra_pkg::cfg_t      cfg,
  input  logic                 fire,
  input  txdra_pkg::item_t     item,
  input  logic [10:0]          rd_lines,
  output txdra_pkg::result_t   result,
  output txdra_pkg::slot_wr_t  slot_wr,
  output logic [7:0]           rd_index_nxt
);
  import txdra_pkg::*;

  logic [31:0] bwa_r, bwa_nxt;
  logic [7:0]  dwi_r, dwi_nxt;
  logic [7:0]  cri_r, cri_nxt;
  logic [8:0]  du_r, du_nxt;
  logic [16:0] lu_r, lu_nxt;

  logic [10:0] lines;
  logic [9:0]  du_p1;
  logic [17:0] lu_sum;
  logic        admit;
  logic [8:0]  du_new;
  logic [16:0] lu_new;
  logic [31:0] bwa_new;
  logic [31:0] fixed;
  logic [7:0]  dwi_new;
  logic [7:0]  cri_new;
  logic [16:0] lu_free;
  logic [8:0]  du_free;
  logic        stop;
  logic        wake;
  logic        is_req;

  always_comb begin
    is_req  = (item.mode == MODE_REQUEST);
    lines   = 11'((17'(item.packet_length) + 17'(LINE_PAD)) >> LINE_SHIFT);
    du_p1   = 10'(du_r) + 10'd1;
    lu_sum  = 18'(lu_r) + 18'(lines);
    admit   = (du_p1 <= 10'(cfg.desc_cap)) && (lu_sum <= 18'(cfg.buf_cap));
    du_new  = du_p1[8:0];
    lu_new  = lu_sum[16:0];
    bwa_new = (bwa_r + {15'd0, lines, 6'd0}) & cfg.addr_mask;
    fixed   = bwa_r + {26'd0, item.dma_address[5:0]};
    dwi_new = (dwi_r + 8'd1) & cfg.ring_mask;
    stop    = !(((10'(du_new) + 10'd1) <= 10'(cfg.desc_cap)) &&
                ((18'(lu_new) + 18'(STOP_LINES)) <= 18'(cfg.buf_cap)));

    cri_new = (cri_r + 8'd1) & cfg.ring_mask;
    lu_free = (lu_r > 17'(rd_lines)) ? (lu_r - 17'(rd_lines)) : 17'd0;
    du_free = (du_r != 9'd0) ? (du_r - 9'd1) : 9'd0;
    wake    = ((10'(du_free) + 10'(WAKE_DESC)) <= 10'(cfg.desc_cap)) &&
              ((18'(lu_free) + 18'(WAKE_LINES)) <= 18'(cfg.buf_cap));

    result = '0;
    if (is_req) begin
      result.oversize = (item.packet_length > MAX_LEN_OK);
      if (admit) begin
        result.accepted             = 1'b1;
        result.ring_index           = dwi_r;
        result.descriptor_low_word  = {item.packet_length, port_code(item.egress_port),
                                       fixed};
        result.descriptor_high_word = item.dma_address;
        result.stop_queue           = stop;
      end
    end else begin
      result.accepted   = 1'b1;
      result.ring_index = cri_r;
      result.wake_queue = wake;
    end

    bwa_nxt = bwa_r;
    dwi_nxt = dwi_r;
    cri_nxt = cri_r;
    du_nxt  = du_r;
    lu_nxt  = lu_r;
    if (fire) begin
      if (is_req) begin
        if (admit) begin
          bwa_nxt = bwa_new;
          dwi_nxt = dwi_new;
          du_nxt  = du_new;
          lu_nxt  = lu_new;
        end
      end else begin
        cri_nxt = cri_new;
        du_nxt  = du_free;
        lu_nxt  = lu_free;
      end
    end

    slot_wr.en    = fire && is_req && admit;
    slot_wr.index = dwi_r;
    slot_wr.lines = lines;
    rd_index_nxt  = cri_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwa_r <= '0;
      dwi_r <= '0;
      cri_r <= '0;
      du_r  <= '0;
      lu_r  <= '0;
    end else begin
      bwa_r <= bwa_nxt;
      dwi_r <= dwi_nxt;
      cri_r <= cri_nxt;
      du_r  <= du_nxt;
      lu_r  <= lu_nxt;
    end
  end

endmodule

[rtl/core/tx_descriptor_ring_allocator_core.sv]
// Transmit descriptor ring allocator with packet-buffer line credits.
// Input channel (in_valid / in_stall): one transfer is either a transmit
// request (in_mode 0: length, egress port, DMA address) or a completion
// event (in_mode 1, other fields ignored). Output channel (out_valid /
// out_stall): exactly one result transfer per input transfer, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 ring
// capacity, 1 buffer lines, 2 buffer address mask, 3 ring index mask);
// write only while no transfer is in flight.
// Path: an input transfer lands in the input register, is evaluated from
// there, and its result is registered into the output register when the
// evaluation stage advances; a stalled output can hold it in between.
// Throughput: one item per cycle while out_stall is low; the line-count
// table read is prefetched into a register for the next completion slot,
// so the table port never limits the rate.
// Reset (rst_n low, synchronous): pointers and usage counts clear, config
// registers return to their defaults, both channels empty. The line-count
// table is not cleared. While out_stall holds back a valid result, the
// evaluation stage keeps its item and in_stall rises once it is occupied.
module tx_descriptor_ring_allocator_core #(
  parameter int RING_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [15:0]                       in_packet_length,
  input  logic [1:0]                        in_egress_port,
  input  logic [63:0]                       in_dma_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [7:0]                        out_ring_index,
  output logic [63:0]                       out_descriptor_low_word,
  output logic [63:0]                       out_descriptor_high_word,
  output logic                              out_stop_queue,
  output logic                              out_wake_queue,
  output logic                              out_oversize,
  input  logic                              cfg_we,
  input  logic [txdra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [txdra_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import txdra_pkg::*;

  cfg_t     cfg;
  item_t    item_r;
  logic     item_valid_r, item_valid_nxt;
  result_t  res_r;
  result_t  res;
  logic     out_valid_r, out_valid_nxt;
  logic     advance;
  logic     take;
  slot_wr_t slot_wr;
  logic [7:0]  rd_index_nxt;
  logic [10:0] rd_lines;

  // Evaluate the held item when the output register is free or drains now
  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (take) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.mode          <= in_mode;
      item_r.packet_length <= in_packet_length;
      item_r.egress_port   <= in_egress_port;
      item_r.dma_address   <= in_dma_address;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  txdra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  txdra_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .fire         (advance),
    .item         (item_r),
    .rd_lines     (rd_lines),
    .result       (res),
    .slot_wr      (slot_wr),
    .rd_index_nxt (rd_index_nxt)
  );

  txdra_slot_mem #(
    .RING_DEPTH (RING_DEPTH)
  ) u_slot_mem (
    .clk      (clk),
    .slot_wr  (slot_wr),
    .rd_index (rd_index_nxt),
    .rd_lines (rd_lines)
  );

  assign out_valid                = out_valid_r;
  assign out_accepted             = res_r.accepted;
  assign out_ring_index           = res_r.ring_index;
  assign out_descriptor_low_word  = res_r.descriptor_low_word;
  assign out_descriptor_high_word = res_r.descriptor_high_word;
  assign out_stop_queue           = res_r.stop_queue;
  assign out_wake_queue           = res_r.wake_queue;
  assign out_oversize             = res_r.oversize;

endmodule

[rtl/core/txdra_checker.sv]
`include "assert_macros.svh"

module txdra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_accepted,
  input logic [7:0]  out_ring_index,
  input logic [63:0] out_descriptor_low_word,
  input logic [63:0] out_descriptor_high_word,
  input logic        out_stop_queue,
  input logic        out_wake_queue,
  input logic        out_oversize
);

  // A rejected request carries nothing but the oversize flag
  `TXDRA_ASSERT_IMP(a_reject_clean, clk, rst_n, out_valid && !out_accepted, out_ring_index == 8'd0 && out_descriptor_low_word == 64'd0 && out_descriptor_high_word == 64'd0 && !out_stop_queue && !out_wake_queue)

  // Wake comes only from a completion, which never carries descriptor words
  `TXDRA_ASSERT_IMP(a_wake_is_completion, clk, rst_n, out_valid && out_wake_queue, out_accepted && !out_stop_queue && !out_oversize && out_descriptor_low_word == 64'd0 && out_descriptor_high_word == 64'd0)

  // A nonzero port code in an accepted result's low word is one of the four codes
  `TXDRA_ASSERT_IMP(a_admit_port_code, clk, rst_n, out_valid && out_accepted && out_descriptor_low_word[47:32] != 16'd0, out_descriptor_low_word[47:32] == 16'h0102 || out_descriptor_low_word[47:32] == 16'h0408 || out_descriptor_low_word[47:32] == 16'h1020 || out_descriptor_low_word[47:32] == 16'h4080)

  // A stalled result holds
  `TXDRA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_descriptor_low_word) && $stable(out_ring_index))

endmodule

bind tx_descriptor_ring_allocator_core txdra_checker u_txdra_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_accepted             (out_accepted),
  .out_ring_index           (out_ring_index),
  .out_descriptor_low_word  (out_descriptor_low_word),
  .out_descriptor_high_word (out_descriptor_high_word),
  .out_stop_queue           (out_stop_queue),
  .out_wake_queue           (out_wake_queue),
  .out_oversize             (out_oversize)
);

[tb/tx_descriptor_ring_allocator_checker.sv]
module tx_descriptor_ring_allocator_checker #(
  parameter int RING_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_mode,
  input  logic [15:0]                      in_packet_length,
  input  logic [1:0]                       in_egress_port,
  input  logic [63:0]                      in_dma_address,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_accepted,
  input  logic [7:0]                       out_ring_index,
  input  logic [63:0]                      out_descriptor_low_word,
  input  logic [63:0]                      out_descriptor_high_word,
  input  logic                             out_stop_queue,
  input  logic                             out_wake_queue,
  input  logic                             out_oversize,
  input  logic                             cfg_we,
  input  logic [txdra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [txdra_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               outstanding
);
  import txdra_pkg::*;

  localparam logic [16:0] PAD_BYTES     = 17'd126;
  localparam logic [15:0] LEN_LIMIT     = 16'd1514;
  localparam int unsigned STOP_HEADROOM = 32;
  localparam int unsigned WAKE_DESCS    = 8;
  localparam int unsigned WAKE_LINES    = 128;

  // Allocator state as the block should hold it
  cfg_t        regs;
  logic [31:0] buf_wr_addr;
  logic [7:0]  desc_wr_idx;
  logic [7:0]  cpl_rd_idx;
  logic [8:0]  descs_out;
  logic [16:0] lines_out;
  logic [10:0] slot_lines [RING_DEPTH];

  result_t pending_results [$];
  int      in_xfers;
  int      out_xfers;

  assign outstanding = in_xfers - out_xfers;

  task automatic allocate_or_release(input item_t it, output result_t r);
    logic [16:0] padded;
    logic [10:0] need;
    logic [10:0] freed;
    logic [31:0] base;
    logic [7:0]  slot;
    logic [15:0] code;
    int unsigned du, lu, cap_d, cap_l;
    r = '0;
    cap_d = regs.desc_cap;
    cap_l = regs.buf_cap;
    if (it.mode == MODE_REQUEST) begin
      padded = {1'b0, it.packet_length} + PAD_BYTES;
      need = padded[16:6];
      r.oversize = (it.packet_length > LEN_LIMIT);
      du = descs_out;
      lu = lines_out;
      if ((du + 1 <= cap_d) && (lu + need <= cap_l)) begin
        case (it.egress_port)
          2'd0: code = 16'h0102;
          2'd1: code = 16'h0408;
          2'd2: code = 16'h1020;
          default: code = 16'h4080;
        endcase
        base = buf_wr_addr;
        slot = desc_wr_idx;
        r.accepted = 1'b1;
        r.ring_index = slot;
        r.descriptor_low_word = {it.packet_length, code, base + {26'b0, it.dma_address[5:0]}};
        r.descriptor_high_word = it.dma_address;
        buf_wr_addr = (base + {15'b0, need, 6'b0}) & regs.addr_mask;
        desc_wr_idx = (slot + 8'd1) & regs.ring_mask;
        descs_out = descs_out + 9'd1;
        lines_out = lines_out + {6'b0, need};
        slot_lines[slot % RING_DEPTH] = need;
        du = descs_out;
        lu = lines_out;
        r.stop_queue = !((du + 1 <= cap_d) && (lu + STOP_HEADROOM <= cap_l));
      end
    end else begin
      slot = cpl_rd_idx;
      freed = slot_lines[slot % RING_DEPTH];
      cpl_rd_idx = (slot + 8'd1) & regs.ring_mask;
      // saturate both counts at zero
      lines_out = (lines_out > {6'b0, freed}) ? lines_out - {6'b0, freed} : 17'd0;
      if (descs_out != 9'd0) descs_out = descs_out - 9'd1;
      du = descs_out;
      lu = lines_out;
      r.accepted = 1'b1;
      r.ring_index = slot;
      r.wake_queue = (du + WAKE_DESCS <= cap_d) && (lu + WAKE_LINES <= cap_l);
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    item_t   seen;
    if (!rst_n) begin
      regs.desc_cap = 9'd256;
      regs.buf_cap = 16'd1024;
      regs.addr_mask = 32'h0000_ffff;
      regs.ring_mask = 8'hff;
      buf_wr_addr = '0;
      desc_wr_idx = '0;
      cpl_rd_idx = '0;
      descs_out = '0;
      lines_out = '0;
      pending_results.delete();
      in_xfers <= 0;
      out_xfers <= 0;
    end else begin
      // retire the oldest expectation before queueing a new one
      if (out_valid && !out_stall) begin
        out_xfers <= out_xfers + 1;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with none expected, expected nothing, actual %0h",
                   $time, out_ring_index);
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("ring_index", want.ring_index, out_ring_index);
          check_field("descriptor_low_word", want.descriptor_low_word,
                      out_descriptor_low_word);
          check_field("descriptor_high_word", want.descriptor_high_word,
                      out_descriptor_high_word);
          check_field("stop_queue", want.stop_queue, out_stop_queue);
          check_field("wake_queue", want.wake_queue, out_wake_queue);
          check_field("oversize", want.oversize, out_oversize);
        end
      end
      if (in_valid && !in_stall) begin
        seen.mode = in_mode;
        seen.packet_length = in_packet_length;
        seen.egress_port = in_egress_port;
        seen.dma_address = in_dma_address;
        allocate_or_release(seen, fresh);
        pending_results.push_back(fresh);
        in_xfers <= in_xfers + 1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DESC_CAP:  regs.desc_cap = cfg_data[8:0];
          CFG_BUF_CAP:   regs.buf_cap = cfg_data[15:0];
          CFG_ADDR_MASK: regs.addr_mask = cfg_data[31:0];
          CFG_RING_MASK: regs.ring_mask = cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/testbench.sv]
module testbench;
  import txdra_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int END_WAIT_CAP = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [15:0] in_packet_length;
  logic [1:0]  in_egress_port;
  logic [63:0] in_dma_address;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [7:0]  out_ring_index;
  logic [63:0] out_descriptor_low_word;
  logic [63:0] out_descriptor_high_word;
  logic        out_stop_queue;
  logic        out_wake_queue;
  logic        out_oversize;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;

  // Stimulus bookkeeping for the closing summary
  int requests_sent = 0;
  int completions_sent = 0;
  int settings_used = 1;

  // Idle bursts on the input side and stall bursts on the result side
  bit idle_on;
  bit stall_on;
  int stall_left = 0;

  tx_descriptor_ring_allocator_core #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_mode                  (in_mode),
    .in_packet_length         (in_packet_length),
    .in_egress_port           (in_egress_port),
    .in_dma_address           (in_dma_address),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_accepted             (out_accepted),
    .out_ring_index           (out_ring_index),
    .out_descriptor_low_word  (out_descriptor_low_word),
    .out_descriptor_high_word (out_descriptor_high_word),
    .out_stop_queue           (out_stop_queue),
    .out_wake_queue           (out_wake_queue),
    .out_oversize             (out_oversize),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  tx_descriptor_ring_allocator_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold off result transfers in randomly started bursts of random length;
  // drop the stall entirely once stall_on is cleared for the closing stretch.
  always @(posedge clk) begin
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Mostly ordinary frame sizes, with the extremes and the oversize
  // boundary showing up regularly.
  function automatic logic [15:0] pick_length();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 65535));
      3: return ($urandom_range(0, 1) == 0) ? 16'd1514 : 16'd1515;
      default: return 16'($urandom_range(0, 1600));
    endcase
  endfunction

  // Present one item and hold it until the block takes the transfer. An
  // optional idle burst comes first; valid stays high between
  // back-to-back items.
  task automatic send_item(input logic mode, input logic [15:0] len,
                           input logic [1:0] port, input logic [63:0] dma);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_packet_length <= len;
    in_egress_port <= port;
    in_dma_address <= dma;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode == MODE_REQUEST) requests_sent++;
    else completions_sent++;
  endtask

  task automatic random_items(input int count, input int unsigned complete_pct);
    logic mode;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 99) < complete_pct) ? MODE_COMPLETE : MODE_REQUEST;
      send_item(mode, pick_length(), 2'($urandom_range(0, 3)), {$urandom, $urandom});
    end
  endtask

  // Drop valid and let every transfer in flight drain out of the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all four registers back to back; optionally follow with a write
  // to an unused index, which the block must ignore.
  task automatic configure(input logic [8:0] ring_cap, input logic [15:0] line_cap,
                           input logic [31:0] addr_mask, input logic [7:0] ring_mask,
                           input bit stray);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_DESC_CAP;
    cfg_data <= {23'b0, ring_cap};
    @(posedge clk);
    cfg_index <= CFG_BUF_CAP;
    cfg_data <= {16'b0, line_cap};
    @(posedge clk);
    cfg_index <= CFG_ADDR_MASK;
    cfg_data <= addr_mask;
    @(posedge clk);
    cfg_index <= CFG_RING_MASK;
    cfg_data <= {24'b0, ring_mask};
    @(posedge clk);
    if (stray) begin
      cfg_index <= CFG_RING_MASK + CFG_IDX_W'(1 + $urandom_range(0, 3));
      cfg_data <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_REQUEST;
    in_packet_length = '0;
    in_egress_port = '0;
    in_dma_address = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DESC_CAP;
    cfg_data = '0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole ring under the reset settings so that every line-count
    // slot holds a value before any completion reads it. Lengths stay at or
    // below 130 bytes (4 lines) so all 256 fit in the 1024-line buffer.
    for (int i = 0; i < 256; i++) begin
      send_item(MODE_REQUEST,
                (i == 0) ? 16'd0 : (i == 255) ? 16'd130 : 16'($urandom_range(0, 130)),
                2'(i),
                (i == 0) ? 64'd0 : (i == 1) ? '1 : {$urandom, $urandom});
    end

    // Ring is full: every request bounces, oversize is still flagged.
    send_item(MODE_REQUEST, 16'd0, 2'd0, 64'd0);
    send_item(MODE_REQUEST, 16'hffff, 2'd3, '1);
    send_item(MODE_REQUEST, 16'd1515, 2'd1, {$urandom, $urandom});
    send_item(MODE_REQUEST, 16'd1514, 2'd2, {$urandom, $urandom});
    // Free a few slots, then admit into the gap.
    repeat (4) send_item(MODE_COMPLETE, pick_length(), 2'($urandom_range(0, 3)),
                         {$urandom, $urandom});
    send_item(MODE_REQUEST, 16'd0, 2'd1, 64'h0000_0000_0000_003f);
    send_item(MODE_REQUEST, 16'd130, 2'd2, {$urandom, $urandom});
    send_item(MODE_REQUEST, 16'd1514, 2'd3, {$urandom, $urandom});

    // Zero descriptor capacity: nothing is admitted, wake never fires.
    configure(9'd0, 16'd1024, 32'h0000_ffff, 8'hff, 1'b0);
    random_items(30, 50);

    // Widest settings: drain past empty so both counts saturate, then mix.
    configure(9'd256, 16'hffff, 32'hffff_ffff, 8'hff, 1'b0);
    random_items(260, 100);
    random_items(150, 40);

    // Tight ring and buffer with a short index wrap.
    configure(9'd8, 16'd64, 32'h0000_0fff, 8'h07, 1'b0);
    random_items(200, 45);

    // Zero buffer and zero masks: every request is rejected.
    configure(9'd1, 16'd0, 32'd0, 8'h00, 1'b0);
    random_items(30, 50);

    // Random settings, one with a write to an unused register index.
    configure(9'($urandom_range(0, 256)), 16'($urandom), $urandom, 8'($urandom), 1'b1);
    random_items(150, 50);
    configure(9'($urandom_range(1, 256)), 16'($urandom_range(64, 4096)), $urandom,
              8'($urandom), 1'b0);
    random_items(100, 50);

    // Closing stretch at full rate: no idle cycles, no stalls.
    configure(9'd256, 16'd1024, 32'h0000_ffff, 8'hff, 1'b0);
    idle_on = 1'b0;
    stall_on = 1'b0;
    random_items(120, 50);

    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < END_WAIT_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (outstanding != 0)
      $display("%0t: results never delivered, expected 0 outstanding, actual %0d",
               $time, outstanding);
    $display("Exercised %0d transmit requests and %0d completion events across %0d settings",
             requests_sent, completions_sent, settings_used);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tx_descriptor_ring_allocator_core verification clean");
    end else begin
      $display("tx_descriptor_ring_allocator_core verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tx_descriptor_ring_allocator_core verification failed");
    $finish;
  end

endmodule
